/* sv/triangle_tile_rasterizer_unit_defines.svh */
// ============================================================================
// Triangle tile rasterizer assertion macros
// Shared property templates for the concurrent checks of the design.
// ============================================================================
`ifndef TRIANGLE_TILE_RASTERIZER_UNIT_DEFINES_SVH
`define TRIANGLE_TILE_RASTERIZER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TRR_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("trr check failed");

// The consequent must hold in the cycle after the antecedent.
`define TRR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("trr check failed");

`endif

/* sv/trr_pkg.sv */
// ============================================================================
// Triangle tile rasterizer package
// Shared constants and the task word passed from the front end to the back end.
// ============================================================================
`timescale 1ns / 1ps

package trr_pkg;

    localparam int FRAME_DIM_DEF     = 256;
    localparam int TILE_SIZE_DEF     = 8;
    localparam int SUBPIXEL_BITS_DEF = 4;
    localparam int QUEUE_DEPTH_DEF   = 4;

    localparam int COORD_W  = 14;
    localparam int COLOR_W  = 24;
    localparam int DEPTH_W  = 16;
    localparam int TILE_W   = 5;
    localparam int PIX_W    = 8;
    localparam int CHAN_W   = 8;
    localparam int AREA_W   = 32;
    localparam int S_DATA_W = 184;
    localparam int M_DATA_W = 56;

    typedef struct packed {
        logic [PIX_W-1:0]              col;
        logic [PIX_W-1:0]              row;
        logic [2:0][AREA_W-1:0]        w;
        logic [AREA_W-1:0]             area;
        logic [2:0][COLOR_W-1:0]       color;
        logic [DEPTH_W-1:0]            depth;
        logic                          covered;
        logic                          last;
    } trr_task_t;

endpackage

/* sv/trr_fifo.sv */
// ============================================================================
// Triangle tile rasterizer task queue
// Small register queue between the pixel walker and the shading pipeline.
// ============================================================================
`timescale 1ns / 1ps
`include "triangle_tile_rasterizer_unit_defines.svh"

module trr_fifo #(
    parameter int DEPTH = trr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  trr_pkg::trr_task_t push_data,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output trr_pkg::trr_task_t head_data
);
    import trr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    trr_task_t        mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      cnt_reg;

    assign full       = (cnt_reg == (AW+1)'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    `TRR_ASSERT_SAME(a_no_overflow, aclk, aresetn, push, cnt_reg != (AW+1)'(DEPTH))
    `TRR_ASSERT_SAME(a_no_underflow, aclk, aresetn, pop, cnt_reg != '0)
    `TRR_ASSERT_NEXT(a_count_up, aclk, aresetn, push && !pop, cnt_reg == $past(cnt_reg) + 1'b1)

endmodule

/* sv/trr_front.sv */
// ============================================================================
// Triangle tile rasterizer front end
// Sets up the edge functions of a triangle and walks the tile, queueing
// every covered pixel and flagging the last one, or one empty last word.
// ============================================================================
`timescale 1ns / 1ps

module trr_front #(
    parameter int FRAME_DIM     = trr_pkg::FRAME_DIM_DEF,
    parameter int TILE_SIZE     = trr_pkg::TILE_SIZE_DEF,
    parameter int SUBPIXEL_BITS = trr_pkg::SUBPIXEL_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [trr_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          task_push,
    output trr_pkg::trr_task_t            task_data,
    input  logic                          task_full
);
    import trr_pkg::*;

    localparam int TW  = $clog2(TILE_SIZE);
    localparam int PW  = 9 + SUBPIXEL_BITS;
    localparam int DW  = ((PW > 15) ? PW : 15) + 2;
    localparam int PRW = DW + 16;
    localparam int EW  = PRW + 1;
    localparam int SW  = SUBPIXEL_BITS + 1;
    localparam int A_IDX [3] = '{1, 2, 0};
    localparam int B_IDX [3] = '{2, 0, 1};
    localparam logic [10:0]   IMG  = 11'(FRAME_DIM);
    localparam logic [TW-1:0] TMAX = TW'(TILE_SIZE - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_SUB  = 3'd2;
    localparam logic [2:0] ST_WALK = 3'd3;
    localparam logic [2:0] ST_END  = 3'd4;

    logic                 in_valid_reg;
    logic [S_DATA_W-1:0]  in_data_reg;
    logic [2:0]           state_reg;
    logic [2:0]           state_next;

    logic signed [14:0]   vx_in [3];
    logic signed [14:0]   vy_in [3];
    logic [8:0]           col0_in;
    logic [8:0]           row0_in;
    logic signed [DW-1:0] px0_s;
    logic signed [DW-1:0] py0_s;

    logic signed [DW-1:0]  ox_reg [3];
    logic signed [DW-1:0]  oy_reg [3];
    logic signed [15:0]    dx_reg [3];
    logic signed [15:0]    dy_reg [3];
    logic signed [15:0]    adx_reg;
    logic signed [15:0]    ady_reg;
    logic signed [PRW-1:0] p1_reg [3];
    logic signed [PRW-1:0] p2_reg [3];
    logic signed [PRW-1:0] ap1_reg;
    logic signed [PRW-1:0] ap2_reg;
    logic signed [EW-1:0]  w_reg [3];
    logic signed [EW-1:0]  wc_reg [3];
    logic signed [EW-1:0]  area_reg;
    logic signed [EW-1:0]  stepc [3];
    logic signed [EW-1:0]  stepr [3];
    logic [8:0]            col0_reg;
    logic [8:0]            row0_reg;
    logic [TW-1:0]         i_reg;
    logic [TW-1:0]         j_reg;
    logic [2:0][COLOR_W-1:0] color_reg;
    logic [DEPTH_W-1:0]    depth_reg;
    trr_task_t             pend_reg;
    logic                  pend_valid_reg;

    logic       take;
    logic       walk_go;
    logic       end_go;
    logic       cov;
    logic       area_pos;
    logic [8:0] col;
    logic [8:0] row;
    trr_task_t  cur_task;
    trr_task_t  empty_task;

    assign s_tready = !in_valid_reg;
    assign take     = (state_reg == ST_IDLE) && in_valid_reg;
    assign walk_go  = (state_reg == ST_WALK) && !task_full;
    assign end_go   = (state_reg == ST_END) && !task_full;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            vx_in[k] = $signed({in_data_reg[28*k +: COORD_W], 1'b0});
            vy_in[k] = $signed({in_data_reg[28*k + 14 +: COORD_W], 1'b0});
        end
        col0_in = 9'(in_data_reg[172 +: TILE_W] * TILE_SIZE);
        row0_in = 9'(in_data_reg[177 +: TILE_W] * TILE_SIZE);
        px0_s   = $signed(DW'(PW'({col0_in, 1'b1}) << SUBPIXEL_BITS));
        py0_s   = $signed(DW'(PW'({row0_in, 1'b1}) << SUBPIXEL_BITS));
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            stepc[k] = EW'(dy_reg[k]) <<< SW;
            stepr[k] = -(EW'(dx_reg[k]) <<< SW);
        end
    end

    assign col      = col0_reg + 9'(i_reg);
    assign row      = row0_reg + 9'(j_reg);
    assign area_pos = !area_reg[EW-1] && (area_reg != '0);
    assign cov      = !w_reg[0][EW-1] && !w_reg[1][EW-1] && !w_reg[2][EW-1] && area_pos
                   && (11'(col) < IMG) && (11'(row) < IMG);

    always_comb begin
        cur_task         = '0;
        cur_task.col     = col[PIX_W-1:0];
        cur_task.row     = row[PIX_W-1:0];
        for (int k = 0; k < 3; k++) begin
            cur_task.w[k] = w_reg[k][AREA_W-1:0];
        end
        cur_task.area    = area_reg[AREA_W-1:0];
        cur_task.color   = color_reg;
        cur_task.depth   = depth_reg;
        cur_task.covered = 1'b1;
        cur_task.last    = 1'b0;
        empty_task       = '0;
        empty_task.last  = 1'b1;
    end

    always_comb begin
        task_push = (walk_go && cov && pend_valid_reg) || end_go;
        if (state_reg == ST_END) begin
            if (pend_valid_reg) begin
                task_data      = pend_reg;
                task_data.last = 1'b1;
            end else begin
                task_data = empty_task;
            end
        end else begin
            task_data = pend_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid_reg) state_next = ST_MUL;
            ST_MUL:  state_next = ST_SUB;
            ST_SUB:  state_next = ST_WALK;
            ST_WALK: if (walk_go && j_reg == TMAX && i_reg == TMAX) state_next = ST_END;
            ST_END:  if (end_go) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
        end else begin
            state_reg <= state_next;
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (take) begin
                in_valid_reg <= 1'b0;
            end
            if (take) begin
                i_reg <= '0;
                j_reg <= '0;
            end else if (walk_go) begin
                if (cov) begin
                    pend_valid_reg <= 1'b1;
                end
                if (j_reg == TMAX) begin
                    j_reg <= '0;
                    i_reg <= i_reg + 1'b1;
                end else begin
                    j_reg <= j_reg + 1'b1;
                end
            end else if (end_go) begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
        end
        if (take) begin
            for (int k = 0; k < 3; k++) begin
                ox_reg[k] <= px0_s - DW'(vx_in[A_IDX[k]]);
                oy_reg[k] <= py0_s - DW'(vy_in[A_IDX[k]]);
                dx_reg[k] <= 16'(vx_in[B_IDX[k]]) - 16'(vx_in[A_IDX[k]]);
                dy_reg[k] <= 16'(vy_in[B_IDX[k]]) - 16'(vy_in[A_IDX[k]]);
                color_reg[k] <= in_data_reg[84 + 24*k +: COLOR_W];
            end
            adx_reg   <= 16'(vx_in[2]) - 16'(vx_in[0]);
            ady_reg   <= 16'(vy_in[2]) - 16'(vy_in[0]);
            col0_reg  <= col0_in;
            row0_reg  <= row0_in;
            depth_reg <= in_data_reg[156 +: DEPTH_W];
        end
        if (state_reg == ST_MUL) begin
            for (int k = 0; k < 3; k++) begin
                p1_reg[k] <= ox_reg[k] * dy_reg[k];
                p2_reg[k] <= oy_reg[k] * dx_reg[k];
            end
            ap1_reg <= adx_reg * dy_reg[2];
            ap2_reg <= ady_reg * dx_reg[2];
        end
        if (state_reg == ST_SUB) begin
            for (int k = 0; k < 3; k++) begin
                w_reg[k]  <= EW'(p1_reg[k]) - EW'(p2_reg[k]);
                wc_reg[k] <= EW'(p1_reg[k]) - EW'(p2_reg[k]);
            end
            area_reg <= EW'(ap1_reg) - EW'(ap2_reg);
        end
        if (walk_go) begin
            if (cov) begin
                pend_reg <= cur_task;
            end
            for (int k = 0; k < 3; k++) begin
                if (j_reg == TMAX) begin
                    wc_reg[k] <= wc_reg[k] + stepc[k];
                    w_reg[k]  <= wc_reg[k] + stepc[k];
                end else begin
                    w_reg[k] <= w_reg[k] + stepr[k];
                end
            end
        end
    end

endmodule

/* sv/trr_back.sv */
// ============================================================================
// Triangle tile rasterizer back end
// Weights the vertex colors of each queued pixel and divides by the area in
// a pipelined restoring divider, one quotient bit per stage.
// ============================================================================
`timescale 1ns / 1ps

module trr_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          task_valid,
    input  trr_pkg::trr_task_t            task_data,
    output logic                          task_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [trr_pkg::M_DATA_W-1:0]  m_tdata,
    output logic [0:0]                    m_tuser,
    output logic                          m_tlast
);
    import trr_pkg::*;

    localparam int PRODW = AREA_W + CHAN_W;
    localparam int DVW   = PRODW + 2;
    localparam int QB    = CHAN_W;

    typedef struct packed {
        logic [PIX_W-1:0]   col;
        logic [PIX_W-1:0]   row;
        logic [AREA_W-1:0]  area;
        logic [DEPTH_W-1:0] depth;
        logic               covered;
        logic               last;
    } trr_meta_t;

    logic                  adv;
    logic                  v0_reg;
    trr_task_t             t0_reg;
    logic                  v1_reg;
    trr_meta_t             meta1_reg;
    logic [PRODW-1:0]      prod_reg [3][3];
    logic                  dv_reg   [QB+1];
    trr_meta_t             dmeta_reg [QB+1];
    logic [DVW-1:0]        rem_reg  [QB+1][3];
    logic [CHAN_W-1:0]     q_reg    [QB+1][3];
    logic                  out_valid_reg;
    logic [M_DATA_W-1:0]   out_data_reg;
    logic                  out_cov_reg;
    logic                  out_last_reg;
    trr_meta_t             meta0;
    trr_meta_t             mfin;

    assign adv      = !out_valid_reg || m_tready;
    assign task_pop = adv && task_valid;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_cov_reg;
    assign m_tlast  = out_last_reg;

    always_comb begin
        meta0.col     = t0_reg.col;
        meta0.row     = t0_reg.row;
        meta0.area    = t0_reg.area;
        meta0.depth   = t0_reg.depth;
        meta0.covered = t0_reg.covered;
        meta0.last    = t0_reg.last;
        mfin          = dmeta_reg[QB];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int n = 0; n <= QB; n++) begin
                dv_reg[n] <= 1'b0;
            end
        end else if (adv) begin
            v0_reg    <= task_valid;
            v1_reg    <= v0_reg;
            dv_reg[0] <= v1_reg;
            for (int n = 1; n <= QB; n++) begin
                dv_reg[n] <= dv_reg[n-1];
            end
            out_valid_reg <= dv_reg[QB];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t0_reg    <= task_data;
            meta1_reg <= meta0;
            for (int c = 0; c < 3; c++) begin
                for (int v = 0; v < 3; v++) begin
                    prod_reg[c][v] <= t0_reg.w[v] * PRODW'(t0_reg.color[v][16 - 8*c +: CHAN_W]);
                end
            end
            dmeta_reg[0] <= meta1_reg;
            for (int c = 0; c < 3; c++) begin
                rem_reg[0][c] <= DVW'(prod_reg[c][0]) + DVW'(prod_reg[c][1])
                               + DVW'(prod_reg[c][2]);
                q_reg[0][c]   <= '0;
            end
            for (int n = 1; n <= QB; n++) begin
                dmeta_reg[n] <= dmeta_reg[n-1];
                for (int c = 0; c < 3; c++) begin
                    if (rem_reg[n-1][c] >= (DVW'(dmeta_reg[n-1].area) << (QB - n))) begin
                        rem_reg[n][c] <= rem_reg[n-1][c]
                                       - (DVW'(dmeta_reg[n-1].area) << (QB - n));
                        q_reg[n][c]   <= q_reg[n-1][c] | CHAN_W'(1 << (QB - n));
                    end else begin
                        rem_reg[n][c] <= rem_reg[n-1][c];
                        q_reg[n][c]   <= q_reg[n-1][c];
                    end
                end
            end
            out_data_reg <= mfin.covered
                          ? {mfin.depth, q_reg[QB][2], q_reg[QB][1], q_reg[QB][0],
                             mfin.row, mfin.col}
                          : '0;
            out_cov_reg  <= mfin.covered;
            out_last_reg <= mfin.last;
        end
    end

endmodule

/* sv/triangle_tile_rasterizer_unit.sv */
// One triangle and one tile position go in as a word; out come the covered
// pixels of the tile, column by column and upward within a column, each with
// its interpolated color and the depth, the last one flagged on tlast. A tile
// with nothing covered gives a single word with tuser low. The front end
// sets up the edge functions in ST_IDLE, ST_MUL and ST_SUB, then visits each
// pixel position of the tile (TILE_SIZE squared, 64 at the default) in ST_WALK
// and closes the tile in ST_END; the walker stalls while the queue is full.
// The shading pipeline behind the queue delivers one word per cycle unless
// m_tready stalls it, and the next input word is taken while a tile is
// still being walked.
// ============================================================================
// Triangle tile rasterizer
// Edge-function rasterizer for one tile, with barycentric color interpolation.
// ============================================================================
`timescale 1ns / 1ps

module triangle_tile_rasterizer_unit #(
    parameter int FRAME_DIM     = trr_pkg::FRAME_DIM_DEF,
    parameter int TILE_SIZE     = trr_pkg::TILE_SIZE_DEF,
    parameter int SUBPIXEL_BITS = trr_pkg::SUBPIXEL_BITS_DEF,
    parameter int QUEUE_DEPTH   = trr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // vx0, vy0, vx1, vy1, vx2, vy2, color0, color1, color2, depth_in,
    // tile_col, tile_row, zero fill
    input  logic [trr_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // pixel_col, pixel_row, red, green, blue, depth_out
    output logic [trr_pkg::M_DATA_W-1:0]  m_tdata,
    // covered
    output logic [0:0]                    m_tuser,
    output logic                          m_tlast
);
    import trr_pkg::*;

    logic      push;
    logic      full;
    logic      pop;
    logic      head_valid;
    trr_task_t push_data;
    trr_task_t head_data;

    trr_front #(
        .FRAME_DIM     (FRAME_DIM),
        .TILE_SIZE     (TILE_SIZE),
        .SUBPIXEL_BITS (SUBPIXEL_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .task_push (push),
        .task_data (push_data),
        .task_full (full)
    );

    trr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_data),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    trr_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .task_valid (head_valid),
        .task_data  (head_data),
        .task_pop   (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

/* tb/tb_triangle_tile_rasterizer_unit.sv */
// ============================================================================
// Triangle tile rasterizer testbench
// Sends triangles and tile positions as words over the input stream. A
// self-contained edge-function model predicts the covered pixels of each tile,
// and every output word is compared with the oldest predicted word. Both
// stream sides idle and stall at random.
// ============================================================================
`timescale 1ns / 1ps

module tb_triangle_tile_rasterizer_unit;

    import trr_pkg::*;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  red;
        logic [PIX_W-1:0]   prow;
        logic [PIX_W-1:0]   pcol;
        logic               covered;
        logic               last;
    } pixel_word_t;

    typedef struct {
        logic signed [COORD_W-1:0] vx [3];
        logic signed [COORD_W-1:0] vy [3];
        logic [COLOR_W-1:0]        color [3];
        logic [DEPTH_W-1:0]        depth;
        logic [TILE_W-1:0]         tcol;
        logic [TILE_W-1:0]         trow;
    } triangle_t;

    localparam int LIMIT_CYCLES = 400000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [0:0]            m_tuser;
    logic                  m_tlast;

    pixel_word_t pixel_queue [$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          hold_off = 1'b0;
    bit          no_stall = 1'b0;

    triangle_tile_rasterizer_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic longint edge_fn(longint ax, longint ay, longint bx, longint by,
                                       longint cx, longint cy);
        return (cx - ax) * (by - ay) - (cy - ay) * (bx - ax);
    endfunction

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Expected words of one tile, in column-major order, added to the queue.
    task automatic predict_tile(triangle_t t);
        longint x [3];
        longint y [3];
        longint area, px, py, w0, w1, w2, s, q;
        int col, row, n, k;
        pixel_word_t p;
        n = 0;
        for (k = 0; k < 3; k++) begin
            x[k] = 2 * longint'(t.vx[k]);
            y[k] = 2 * longint'(t.vy[k]);
        end
        area = edge_fn(x[0], y[0], x[1], y[1], x[2], y[2]);
        if (area > 0) begin
            for (int i = 0; i < 8; i++) begin
                col = t.tcol * 8 + i;
                px = longint'(2 * col + 1) <<< 4;
                for (int j = 0; j < 8; j++) begin
                    row = t.trow * 8 + j;
                    py = longint'(2 * row + 1) <<< 4;
                    w0 = edge_fn(x[1], y[1], x[2], y[2], px, py);
                    w1 = edge_fn(x[2], y[2], x[0], y[0], px, py);
                    w2 = edge_fn(x[0], y[0], x[1], y[1], px, py);
                    if (w0 < 0 || w1 < 0 || w2 < 0) continue;
                    p = '0;
                    p.pcol = col[7:0];
                    p.prow = row[7:0];
                    for (k = 0; k < 3; k++) begin
                        s = w0 * ((t.color[0] >> (16 - 8 * k)) & 8'hFF)
                          + w1 * ((t.color[1] >> (16 - 8 * k)) & 8'hFF)
                          + w2 * ((t.color[2] >> (16 - 8 * k)) & 8'hFF);
                        q = s / area;
                        if (q > 255) q = 255;
                        if (k == 0) p.red = q[7:0];
                        else if (k == 1) p.green = q[7:0];
                        else p.blue = q[7:0];
                    end
                    p.depth = t.depth;
                    p.covered = 1'b1;
                    pixel_queue = {pixel_queue, p};
                    n++;
                end
            end
        end
        if (n == 0) begin
            p = '0;
            p.last = 1'b1;
            pixel_queue = {pixel_queue, p};
        end else begin
            pixel_queue[$].last = 1'b1;
        end
    endtask

    task automatic send_triangle(triangle_t t);
        int gap;
        gap = no_stall ? 0 : gap_length();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        predict_tile(t);
        s_tdata <= {t.trow, t.tcol, t.depth, t.color[2], t.color[1], t.color[0],
                    t.vy[2], t.vx[2], t.vy[1], t.vx[1], t.vy[0], t.vx[0]};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (hold_off) m_tready <= 1'b0;
            else if (no_stall) m_tready <= 1'b1;
            else m_tready <= ($urandom_range(0, 9) < 7);
        end
    end

    always @(posedge aclk) begin
        pixel_word_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata, m_tuser[0], m_tlast};
            if (pixel_queue.size() == 0) begin
                error_count++;
                if (error_count <= 10) $display("unexpected word %h", got);
            end else begin
                want = pixel_queue.pop_front();
                if (got !== want) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: expected %h got %h", want, got);
                end
            end
        end
    end

    function automatic triangle_t random_triangle(bit local_tile);
        triangle_t t;
        int cx, cy;
        t.tcol = TILE_W'($urandom_range(0, 31));
        t.trow = TILE_W'($urandom_range(0, 31));
        cx = t.tcol * 128 + 64;
        cy = t.trow * 128 + 64;
        for (int k = 0; k < 3; k++) begin
            if (local_tile) begin
                t.vx[k] = COORD_W'(cx + $signed($urandom_range(0, 400)) - 200);
                t.vy[k] = COORD_W'(cy + $signed($urandom_range(0, 400)) - 200);
            end else begin
                t.vx[k] = COORD_W'($urandom);
                t.vy[k] = COORD_W'($urandom);
            end
            t.color[k] = COLOR_W'($urandom);
        end
        t.depth = DEPTH_W'($urandom);
        return t;
    endfunction

    // Makes the winding counter-clockwise so that the area is positive.
    function automatic triangle_t fix_winding(triangle_t t);
        triangle_t f;
        f = t;
        if (edge_fn(longint'(t.vx[0]), longint'(t.vy[0]), longint'(t.vx[1]),
                    longint'(t.vy[1]), longint'(t.vx[2]), longint'(t.vy[2])) < 0) begin
            f.vx[1] = t.vx[2]; f.vy[1] = t.vy[2]; f.color[1] = t.color[2];
            f.vx[2] = t.vx[1]; f.vy[2] = t.vy[1]; f.color[2] = t.color[1];
        end
        return f;
    endfunction

    function automatic triangle_t make_triangle(int ax, int ay, int bx, int by, int qx, int qy,
                                                int tc, int tr);
        triangle_t t;
        t.vx[0] = COORD_W'(ax); t.vy[0] = COORD_W'(ay); t.vx[1] = COORD_W'(bx);
        t.vy[1] = COORD_W'(by); t.vx[2] = COORD_W'(qx); t.vy[2] = COORD_W'(qy);
        t.color[0] = 24'hFF0000; t.color[1] = 24'h00FF00; t.color[2] = 24'h0000FF;
        t.depth = 16'hFFFF;
        t.tcol = TILE_W'(tc); t.trow = TILE_W'(tr);
        return t;
    endfunction

    task automatic test_directed();
        triangle_t t;
        // Large triangle with a negative area, which covers nothing of the first tile.
        send_triangle(make_triangle(-8192, -8192, 8191, -8192, -8192, 8191, 0, 0));
        // Same triangle with the other winding covers nothing.
        send_triangle(make_triangle(-8192, -8192, -8192, 8191, 8191, -8192, 0, 0));
        // Degenerate triangle with zero area.
        send_triangle(make_triangle(0, 0, 160, 160, 320, 320, 0, 0));
        // Triangle far from the tile.
        send_triangle(make_triangle(0, 0, 64, 0, 0, 64, 31, 31));
        // Far corner tile with a huge triangle and white vertices.
        t = make_triangle(-8192, -8192, 8191, -8192, 8191, 8191, 31, 31);
        t.color[0] = 24'hFFFFFF; t.color[1] = 24'hFFFFFF; t.color[2] = 24'hFFFFFF;
        t.depth = 16'h0000;
        send_triangle(t);
        // Edges passing exactly through pixel centres.
        send_triangle(make_triangle(8, 8, 120, 8, 8, 120, 0, 0));
        send_triangle(make_triangle(24, 24, 200, 24, 24, 200, 1, 1));
        // Small triangle with a negative area, which covers no pixel.
        send_triangle(make_triangle(32, 32, 48, 32, 32, 48, 0, 0));
        // Edge tiles.
        send_triangle(make_triangle(3000, 0, 4095, 0, 4095, 1000, 31, 0));
        send_triangle(make_triangle(0, 3000, 1000, 4095, 0, 4095, 0, 31));
        for (int k = 0; k < 6; k++) send_triangle(fix_winding(random_triangle(1'b1)));
    endtask

    task automatic test_random();
        triangle_t t;
        for (int n = 0; n < 132; n++) begin
            if ($urandom_range(0, 9) < 8) t = fix_winding(random_triangle(1'b1));
            else t = random_triangle(1'($urandom_range(0, 1)));
            send_triangle(t);
            if (n == 60) no_stall = 1'b1;
            if (n == 80) no_stall = 1'b0;
        end
    endtask

    task automatic test_back_pressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(posedge aclk);
                hold_off = 1'b0;
            end
            for (int n = 0; n < 12; n++) send_triangle(fix_winding(random_triangle(1'b1)));
        join
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random();
        test_back_pressure();
        s_tvalid <= 1'b0;
        while (pixel_queue.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (error_count == 0 && pixel_queue.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
